// ----- rtl/core/pvbpa_pkg.sv -----
// ----------------------------------------------------------------------------
// pvbpa_pkg
// Shared constants, types and the CORDIC angle table of the bin phase
// advance unit.
// ----------------------------------------------------------------------------
package pvbpa_pkg;

  localparam int FRAME_BINS   = 1024;             // power of two
  localparam int FRAME_LOG2   = $clog2(FRAME_BINS);
  localparam int AW           = 10;               // state address bits
  localparam int DEPTH        = 2 ** AW;
  localparam int STAGES       = 15;               // CORDIC iterations
  localparam int XW           = 27;               // CORDIC datapath width
  localparam int ZW           = 18;               // CORDIC angle width
  localparam int OMW          = 28;               // advance kept mod 2^OMW
  localparam int GAIN_FIX     = 24167;            // round(65536/K^2)

  localparam logic REG_HOP   = 1'b0;
  localparam logic REG_RATIO = 1'b1;

  localparam logic [10:0] HOP_RESET   = 11'd512;
  localparam logic [15:0] RATIO_RESET = 16'd4096;

  typedef struct packed {
    logic [AW-1:0]  idx;
    logic           zero;
    logic [OMW-1:0] omega;
  } vec_tag_t;

  // atan(2^-i) as a fraction of a turn, 2^-16 units
  function automatic logic signed [ZW-1:0] turn_atan(input int i);
    logic signed [ZW-1:0] r;
    unique case (i)
      0:       r = ZW'(8192);
      1:       r = ZW'(4836);
      2:       r = ZW'(2555);
      3:       r = ZW'(1297);
      4:       r = ZW'(651);
      5:       r = ZW'(326);
      6:       r = ZW'(163);
      7:       r = ZW'(81);
      8:       r = ZW'(41);
      9:       r = ZW'(20);
      10:      r = ZW'(10);
      11:      r = ZW'(5);
      12:      r = ZW'(3);
      default: r = ZW'(1);
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/core/pvbpa_cordic_vec.sv -----
// ----------------------------------------------------------------------------
// pvbpa_cordic_vec
// Pipelined vectoring CORDIC, one iteration per register stage.
// ----------------------------------------------------------------------------
module pvbpa_cordic_vec import pvbpa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [XW-1:0] in_x,
  input  logic signed [XW-1:0] in_y,
  input  logic signed [ZW-1:0] in_z,
  input  vec_tag_t             in_tag,
  output logic                 out_valid,
  output logic signed [XW-1:0] out_x,
  output logic signed [ZW-1:0] out_z,
  output vec_tag_t             out_tag
);

  logic                 vr [STAGES];
  logic signed [XW-1:0] xr [STAGES];
  logic signed [XW-1:0] yr [STAGES];
  logic signed [ZW-1:0] zr [STAGES];
  vec_tag_t             tr [STAGES];

  genvar k;
  for (k = 0; k < STAGES; k++) begin : g_stage
    logic                 vi;
    logic signed [XW-1:0] xi, yi;
    logic signed [ZW-1:0] zi;
    vec_tag_t             ti;

    if (k == 0) begin : g_first
      assign vi = in_valid;
      assign xi = in_x;
      assign yi = in_y;
      assign zi = in_z;
      assign ti = in_tag;
    end else begin : g_next
      assign vi = vr[k-1];
      assign xi = xr[k-1];
      assign yi = yr[k-1];
      assign zi = zr[k-1];
      assign ti = tr[k-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vr[k] <= 1'b0;
      end else if (en) begin
        vr[k] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tr[k] <= ti;
        if (yi > 0) begin
          xr[k] <= xi + (yi >>> k);
          yr[k] <= yi - (xi >>> k);
          zr[k] <= zi + turn_atan(k);
        end else begin
          xr[k] <= xi - (yi >>> k);
          yr[k] <= yi + (xi >>> k);
          zr[k] <= zi - turn_atan(k);
        end
      end
    end
  end

  assign out_valid = vr[STAGES-1];
  assign out_x     = xr[STAGES-1];
  assign out_z     = zr[STAGES-1];
  assign out_tag   = tr[STAGES-1];

endmodule

// ----- rtl/core/pvbpa_cordic_rot.sv -----
// ----------------------------------------------------------------------------
// pvbpa_cordic_rot
// Pipelined rotation CORDIC, one iteration per register stage.
// ----------------------------------------------------------------------------
module pvbpa_cordic_rot import pvbpa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [XW-1:0] in_x,
  input  logic signed [ZW-1:0] in_a,
  input  logic [AW-1:0]        in_idx,
  output logic                 out_valid,
  output logic signed [XW-1:0] out_x,
  output logic signed [XW-1:0] out_y,
  output logic [AW-1:0]        out_idx
);

  logic                 vr [STAGES];
  logic signed [XW-1:0] xr [STAGES];
  logic signed [XW-1:0] yr [STAGES];
  logic signed [ZW-1:0] ar [STAGES];
  logic [AW-1:0]        ir [STAGES];

  genvar k;
  for (k = 0; k < STAGES; k++) begin : g_stage
    logic                 vi;
    logic signed [XW-1:0] xi, yi;
    logic signed [ZW-1:0] ai;
    logic [AW-1:0]        ii;

    if (k == 0) begin : g_first
      assign vi = in_valid;
      assign xi = in_x;
      assign yi = '0;
      assign ai = in_a;
      assign ii = in_idx;
    end else begin : g_next
      assign vi = vr[k-1];
      assign xi = xr[k-1];
      assign yi = yr[k-1];
      assign ai = ar[k-1];
      assign ii = ir[k-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vr[k] <= 1'b0;
      end else if (en) begin
        vr[k] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ir[k] <= ii;
        if (!ai[ZW-1]) begin
          xr[k] <= xi - (yi >>> k);
          yr[k] <= yi + (xi >>> k);
          ar[k] <= ai - turn_atan(k);
        end else begin
          xr[k] <= xi + (yi >>> k);
          yr[k] <= yi - (xi >>> k);
          ar[k] <= ai + turn_atan(k);
        end
      end
    end
  end

  assign out_valid = vr[STAGES-1];
  assign out_x     = xr[STAGES-1];
  assign out_y     = yr[STAGES-1];
  assign out_idx   = ir[STAGES-1];

endmodule

// ----- rtl/core/phase_vocoder_bin_phase_advance_unit.sv -----
// ----------------------------------------------------------------------------
// phase_vocoder_bin_phase_advance_unit
// Phase vocoder phase propagation for one FFT bin per item.
// ----------------------------------------------------------------------------
// One bin enters per clock unless the output buffer is full; throughput is one
// item per cycle, set by the fully pipelined CORDICs (15 stages each) and
// the read-modify-write of the two per-bin phase memories.
// After reset a clearing pass zeroes all 1024 entries of both memories, one
// entry per cycle; s_tready stays low meanwhile, register writes are taken.
// A two-entry output buffer lets the pipeline keep moving while one result
// waits on m_tready.
// Pipeline: capture, prestep/omega, 15 vectoring, P (prior phase, advance),
// M (ratio multiply), A (synth phase accumulate), R (rotation prestep),
// 15 rotation, G (gain multiply), output.
// ----------------------------------------------------------------------------
module phase_vocoder_bin_phase_advance_unit import pvbpa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input bins
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // bin_index[9:0], bin_re[33:10], bin_im[57:34]
  // output bins
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata    // out_index[9:0], out_re[33:10], out_im[57:34]
);

  localparam int IHW  = AW + 11;
  localparam int NUMW = IHW + 16 + 1;
  localparam int GW   = XW + 16;

  // ---------------- configuration ----------------
  logic [10:0] hop_in;
  logic [15:0] ratio_q12;

  always_ff @(posedge clk) begin
    if (rst) begin
      hop_in    <= HOP_RESET;
      ratio_q12 <= RATIO_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_HOP) begin
        hop_in <= pwdata[10:0];
      end else begin
        ratio_q12 <= pwdata[15:0];
      end
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_RATIO) ? {16'b0, ratio_q12} : {21'b0, hop_in};

  // ---------------- clearing pass ----------------
  logic [AW:0] clr_cnt;
  logic        clearing;

  assign clearing = !clr_cnt[AW];

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // ---------------- flow control ----------------
  logic skid_valid;
  logic en;          // whole pipeline advances

  assign en       = !skid_valid;
  assign s_tready = en && !clearing;

  // ---------------- capture ----------------
  logic                i_valid;
  logic [AW-1:0]       i_idx;
  logic signed [23:0]  i_re, i_im;

  always_ff @(posedge clk) begin
    if (rst) begin
      i_valid <= 1'b0;
    end else if (en) begin
      i_valid <= s_tvalid && s_tready;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      i_idx <= s_tdata[9:0];
      i_re  <= s_tdata[33:10];
      i_im  <= s_tdata[57:34];
    end
  end

  // ---------------- prestep and expected advance ----------------
  logic                 e_valid;
  logic signed [XW-1:0] e_x, e_y;
  logic signed [ZW-1:0] e_z;
  vec_tag_t             e_tag;

  logic [IHW-1:0]       ih;
  logic [NUMW-1:0]      num;
  logic signed [XW-1:0] sx, sy;

  always_comb begin
    ih  = IHW'(i_idx * hop_in);
    num = {1'b0, ih, 16'b0} + NUMW'(FRAME_BINS / 2);
    sx  = XW'(i_re);
    sy  = XW'(i_im);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (en) begin
      e_valid <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // left half plane: turn by half a turn first
      if (i_re[23]) begin
        e_x <= -sx;
        e_y <= -sy;
        e_z <= ZW'(32768);
      end else begin
        e_x <= sx;
        e_y <= sy;
        e_z <= '0;
      end
      e_tag.idx   <= i_idx;
      e_tag.zero  <= (i_re == 24'sd0) && (i_im == 24'sd0);
      e_tag.omega <= OMW'(num >> FRAME_LOG2);
    end
  end

  // ---------------- vectoring ----------------
  logic                 v_valid;
  logic signed [XW-1:0] v_x;
  logic signed [ZW-1:0] v_z;
  vec_tag_t             v_tag;

  pvbpa_cordic_vec u_vec (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (e_valid),
    .in_x      (e_x),
    .in_y      (e_y),
    .in_z      (e_z),
    .in_tag    (e_tag),
    .out_valid (v_valid),
    .out_x     (v_x),
    .out_z     (v_z),
    .out_tag   (v_tag)
  );

  // ---------------- P: prior phase and advance ----------------
  logic [15:0] prior_mem [DEPTH];
  logic [15:0] prior_rd;
  logic        prior_we;
  logic [AW-1:0] prior_wa;
  logic [15:0] prior_wd;

  logic                 p_valid;
  logic [AW-1:0]        p_idx;
  logic [15:0]          p_cur;
  logic signed [XW-1:0] p_mag;
  logic [OMW-1:0]       p_omega;

  // last prior write, covers the read that raced it
  logic          lastp_valid;
  logic [AW-1:0] lastp_idx;
  logic [15:0]   lastp_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (en) begin
      p_valid <= v_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_idx   <= v_tag.idx;
      p_cur   <= v_tag.zero ? 16'd0 : v_z[15:0];
      p_mag   <= v_tag.zero ? '0 : v_x;
      p_omega <= v_tag.omega;
    end
  end

  assign prior_we = clearing || (en && p_valid);
  assign prior_wa = clearing ? clr_cnt[AW-1:0] : p_idx;
  assign prior_wd = clearing ? 16'd0 : p_cur;

  always_ff @(posedge clk) begin
    if (prior_we) begin
      prior_mem[prior_wa] <= prior_wd;
    end
    if (en) begin
      prior_rd <= prior_mem[v_tag.idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clearing) begin
      lastp_valid <= 1'b0;
    end else if (prior_we) begin
      lastp_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (prior_we) begin
      lastp_idx <= prior_wa;
      lastp_val <= prior_wd;
    end
  end

  logic [15:0]    prior_eff;
  logic [15:0]    dev;
  logic [OMW-1:0] adv;

  always_comb begin
    prior_eff = (lastp_valid && lastp_idx == p_idx) ? lastp_val : prior_rd;
    dev       = p_cur - prior_eff - p_omega[15:0];
    // wrapped deviation, sign-extended, plus omega
    adv       = p_omega + {{(OMW-16){dev[15]}}, dev};
  end

  // ---------------- M: ratio multiply ----------------
  logic                 m_valid;
  logic [AW-1:0]        m_idx;
  logic signed [XW-1:0] m_mag;
  logic [OMW-1:0]       m_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (en) begin
      m_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_idx <= p_idx;
      m_mag <= p_mag;
      m_adv <= adv;
    end
  end

  logic [OMW-1:0] prod;
  assign prod = OMW'(m_adv * ratio_q12) + OMW'(2048);

  // ---------------- A: synth phase accumulate ----------------
  logic [15:0]   synth_mem [DEPTH];
  logic [15:0]   synth_rd;
  logic          synth_we;
  logic [AW-1:0] synth_wa;
  logic [15:0]   synth_wd;

  logic                 a_valid;
  logic [AW-1:0]        a_idx;
  logic signed [XW-1:0] a_mag;
  logic [OMW-1:0]       a_prod;

  logic          lasts_valid;
  logic [AW-1:0] lasts_idx;
  logic [15:0]   lasts_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_idx  <= m_idx;
      a_mag  <= m_mag;
      a_prod <= prod;
    end
  end

  logic [15:0] synth_eff;
  logic [15:0] synth_new;

  always_comb begin
    synth_eff = (lasts_valid && lasts_idx == a_idx) ? lasts_val : synth_rd;
    synth_new = synth_eff + a_prod[27:12];
  end

  assign synth_we = clearing || (en && a_valid);
  assign synth_wa = clearing ? clr_cnt[AW-1:0] : a_idx;
  assign synth_wd = clearing ? 16'd0 : synth_new;

  always_ff @(posedge clk) begin
    if (synth_we) begin
      synth_mem[synth_wa] <= synth_wd;
    end
    if (en) begin
      synth_rd <= synth_mem[m_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clearing) begin
      lasts_valid <= 1'b0;
    end else if (synth_we) begin
      lasts_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (synth_we) begin
      lasts_idx <= synth_wa;
      lasts_val <= synth_wd;
    end
  end

  // ---------------- R: rotation prestep ----------------
  logic                 r_valid;
  logic [AW-1:0]        r_idx;
  logic signed [XW-1:0] r_x;
  logic signed [ZW-1:0] r_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (en) begin
      r_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_idx <= a_idx;
      // middle half of the turn: start from the negated vector
      if (synth_new[15] != synth_new[14]) begin
        r_x <= -a_mag;
        r_a <= ZW'(signed'({2'b00, synth_new})) - ZW'(32768);
      end else begin
        r_x <= a_mag;
        r_a <= ZW'(signed'(synth_new));
      end
    end
  end

  // ---------------- rotation ----------------
  logic                 o_valid;
  logic signed [XW-1:0] o_x, o_y;
  logic [AW-1:0]        o_idx;

  pvbpa_cordic_rot u_rot (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (r_valid),
    .in_x      (r_x),
    .in_a      (r_a),
    .in_idx    (r_idx),
    .out_valid (o_valid),
    .out_x     (o_x),
    .out_y     (o_y),
    .out_idx   (o_idx)
  );

  // ---------------- G: gain correction ----------------
  logic                 g_valid;
  logic [AW-1:0]        g_idx;
  logic signed [GW-1:0] g_x, g_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      g_valid <= 1'b0;
    end else if (en) begin
      g_valid <= o_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_idx <= o_idx;
      g_x   <= GW'(o_x) * GW'(GAIN_FIX) + GW'(32768);
      g_y   <= GW'(o_y) * GW'(GAIN_FIX) + GW'(32768);
    end
  end

  function automatic logic [23:0] sat24(input logic signed [GW-1:0] v);
    logic signed [GW-17:0] s;
    s = (GW-16)'(v >>> 16);
    if (s > 27'sd8388607) begin
      return 24'h7FFFFF;
    end else if (s < -27'sd8388608) begin
      return 24'h800000;
    end
    return s[23:0];
  endfunction

  logic [63:0] g_data;
  assign g_data = {6'b0, sat24(g_y), sat24(g_x), g_idx};

  // ---------------- output register and skid ----------------
  logic [63:0] skid_data;
  logic        incoming;

  assign incoming = en && g_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid   <= skid_valid || incoming;
      skid_valid <= 1'b0;
    end else if (incoming) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_tvalid || m_tready) begin
      m_tdata <= skid_valid ? skid_data : g_data;
    end else if (incoming) begin
      skid_data <= g_data;
    end
  end

endmodule

// ----- rtl/core/pvbpa_checker.sv -----
// ----------------------------------------------------------------------------
// pvbpa_checker
// Port-level checks of the bin phase advance unit, bound to the top level.
// ----------------------------------------------------------------------------
module pvbpa_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output item changed while stalled");

  // clearing pass blocks input right after reset
  a_clear: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("input taken during clearing pass");

  // nothing comes out right after reset
  a_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result without an item after reset");

  // padding bits of a result are zero
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[63:58] == 6'b0)
    else $error("nonzero padding in result");

endmodule

bind phase_vocoder_bin_phase_advance_unit pvbpa_checker u_pvbpa_checker (.*);
